>>> design/tlpi_pkg.sv
// Shared types, constants and helpers for the thin-lens point imager.
// Depends on nothing; every other design file uses it by scoped name.
`default_nettype none
package tlpi_pkg;

  // Coordinate format: signed two's complement, CW bits, FRAC_BITS fraction bits
  localparam int CW         = 32;
  localparam int FRAC_BITS  = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int SW         = CW + 4;  // exact width for final sums

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_LENS_X = 3'd0;
  localparam logic [2:0] CFG_LENS_Y = 3'd1;
  localparam logic [2:0] CFG_LENS_Z = 3'd2;
  localparam logic [2:0] CFG_FOCAL  = 3'd3;
  localparam logic [2:0] CFG_WINDOW = 3'd4;
  localparam logic [2:0] CFG_CDEPTH = 3'd5;
  localparam logic [2:0] CFG_MODE   = 3'd6;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] image_x;
    logic signed [CW-1:0] image_y;
    logic signed [CW-1:0] image_z;
    logic signed [CW-1:0] mirrored_z;
    logic                 too_close;
    logic                 overflow;
  } out_t;

  typedef struct packed {
    logic signed [CW-1:0] lens_x;
    logic signed [CW-1:0] lens_y;
    logic signed [CW-1:0] lens_z;
    logic [CW-2:0]        focal;
    logic [CW-2:0]        window;
    logic signed [CW-1:0] cdepth;
    logic                 mode;
  } cfg_t;

  // Classified request handed from front to back; diff lanes are x, y, z
  typedef struct packed {
    logic [2:0][CW:0] diff;   // point - lens, signed CW+1 bits
    logic [CW:0]      den;    // d - f, valid when not close
    logic             close;
  } item_t;

  // One divider lane
  typedef struct packed {
    logic [CW+1:0] rem;
    logic [CW:0]   low;
    logic [CW:0]   quo;
    logic          ovf;
    logic          neg;
  } lane_t;

  typedef struct packed {
    logic          close;
    logic [CW:0]   den;
    lane_t [2:0]   lane;
  } stage_t;

  localparam logic signed [SW-1:0] CMAX_EXT = $signed({{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}});
  localparam logic signed [SW-1:0] CMIN_EXT = ~CMAX_EXT;

  // Saturate to the coordinate range; returns {saturated, value}
  function automatic logic [CW:0] sat_c(logic signed [SW-1:0] v);
    logic [CW:0] res;
    if (v > CMAX_EXT) begin
      res = {1'b1, CMAX_EXT[CW-1:0]};
    end else if (v < CMIN_EXT) begin
      res = {1'b1, CMIN_EXT[CW-1:0]};
    end else begin
      res = {1'b0, v[CW-1:0]};
    end
    return res;
  endfunction

  // Check the high part of the product against the divisor
  function automatic stage_t div_check(stage_t s);
    stage_t o;
    o = s;
    for (int k = 0; k < 3; k++) begin
      o.lane[k].ovf = (s.lane[k].rem >= (CW+2)'(s.den));
    end
    return o;
  endfunction

  // One restoring division step on each lane
  function automatic stage_t div_step(stage_t s);
    stage_t        o;
    logic [CW+1:0] r2;
    o = s;
    for (int k = 0; k < 3; k++) begin
      r2 = {s.lane[k].rem[CW:0], s.lane[k].low[CW]};
      o.lane[k].low = {s.lane[k].low[CW-1:0], 1'b0};
      if (r2 >= (CW+2)'(s.den)) begin
        o.lane[k].rem = r2 - (CW+2)'(s.den);
        o.lane[k].quo = {s.lane[k].quo[CW-1:0], 1'b1};
      end else begin
        o.lane[k].rem = r2;
        o.lane[k].quo = {s.lane[k].quo[CW-1:0], 1'b0};
      end
    end
    return o;
  endfunction

endpackage
`default_nettype wire

>>> design/thin_lens_point_imager_core.sv
// Top level of the thin-lens point imager: configuration registers, front
// end, request queue and back end. Depends on tlpi_pkg, tlpi_front,
// tlpi_fifo and tlpi_back.
//
// Usage: write lens position, focal length, window, center depth and mode
// over cfg_* (cfg_ready is always high) while the block is idle. Send points
// on in_* (accepted when in_valid is high and in_stall low); images come out
// on out_* and are taken when out_valid is high and out_stall low.
// Throughput is one point per cycle while out_stall stays low. From the
// accepting edge into the front register to out_valid a point passes one queue
// write, one multiply stage, one overflow check, CW+1 divide stages (one
// quotient bit each, three lanes side by side) and the output register.
// In integral mode rejected points produce no result.
// A stall on out_* freezes the back end; the queue then fills and in_stall
// rises once it and the front register are full. Reset clears the valid
// flags and queue and loads the register defaults (focal length 1.0).
`default_nettype none
module thin_lens_point_imager_core #(
  parameter int FIFO_DEPTH = tlpi_pkg::FIFO_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire tlpi_pkg::in_t          in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output tlpi_pkg::out_t              out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [tlpi_pkg::CW-1:0] cfg_data
);
  localparam int CW = tlpi_pkg::CW;

  tlpi_pkg::cfg_t  cfg_r;
  tlpi_pkg::item_t q_in, q_head;
  logic            q_push, q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  // Load configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lens_x <= '0;
      cfg_r.lens_y <= '0;
      cfg_r.lens_z <= '0;
      cfg_r.focal  <= (CW-1)'(64'd1 << tlpi_pkg::FRAC_BITS);
      cfg_r.window <= '0;
      cfg_r.cdepth <= '0;
      cfg_r.mode   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tlpi_pkg::CFG_LENS_X: cfg_r.lens_x <= cfg_data;
        tlpi_pkg::CFG_LENS_Y: cfg_r.lens_y <= cfg_data;
        tlpi_pkg::CFG_LENS_Z: cfg_r.lens_z <= cfg_data;
        tlpi_pkg::CFG_FOCAL:  cfg_r.focal  <= cfg_data[CW-2:0];
        tlpi_pkg::CFG_WINDOW: cfg_r.window <= cfg_data[CW-2:0];
        tlpi_pkg::CFG_CDEPTH: cfg_r.cdepth <= cfg_data;
        tlpi_pkg::CFG_MODE:   cfg_r.mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tlpi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  tlpi_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  tlpi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> design/tlpi_front.sv
// Front end: registers each input request, applies the integral-mode filter
// and forms the lens differences and divisor. Uses tlpi_pkg.
`default_nettype none
module tlpi_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tlpi_pkg::cfg_t cfg,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire tlpi_pkg::in_t  in_data,
  input  wire logic           q_full,
  output logic                q_push,
  output tlpi_pkg::item_t     q_data
);
  localparam int CW = tlpi_pkg::CW;
  localparam int EW = CW + 2;

  logic            front_v_r, front_v_nxt;
  tlpi_pkg::item_t front_r, front_nxt;
  logic            take, keep;

  logic signed [EW-1:0] px, py, pz, lx, ly, win;
  logic signed [CW:0]   dz;
  logic [CW:0]          dmag;

  assign in_stall = front_v_r && q_full;
  assign take     = in_valid && !in_stall;
  assign q_push   = front_v_r && !q_full;
  assign q_data   = front_r;

  // Classify the incoming point
  always_comb begin
    px  = EW'(in_data.point_x);
    py  = EW'(in_data.point_y);
    pz  = EW'(in_data.point_z);
    lx  = EW'(cfg.lens_x);
    ly  = EW'(cfg.lens_y);
    win = $signed({3'b0, cfg.window});
    keep = !cfg.mode ||
           ((pz >= EW'(cfg.cdepth)) &&
            (px >= lx - win) && (px <= lx + win) &&
            (py >= ly - win) && (py <= ly + win));
    dz   = (CW+1)'(in_data.point_z) - (CW+1)'(cfg.lens_z);
    dmag = dz[CW] ? (CW+1)'(-dz) : (CW+1)'(dz);
    front_nxt.diff[0] = (CW+1)'(in_data.point_x) - (CW+1)'(cfg.lens_x);
    front_nxt.diff[1] = (CW+1)'(in_data.point_y) - (CW+1)'(cfg.lens_y);
    front_nxt.diff[2] = dz;
    front_nxt.close   = (dmag <= (CW+1)'(cfg.focal));
    front_nxt.den     = dmag - (CW+1)'(cfg.focal);
    if (take) begin
      front_v_nxt = keep;
    end else if (q_push) begin
      front_v_nxt = 1'b0;
    end else begin
      front_v_nxt = front_v_r;
    end
  end

  // Hold the front register until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
    if (take) begin
      front_r <= front_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/tlpi_fifo.sv
// Short request queue between front and back end.
// Uses tlpi_pkg for the request type.
`default_nettype none
module tlpi_fifo #(
  parameter int DEPTH = tlpi_pkg::FIFO_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire tlpi_pkg::item_t push_data,
  input  wire logic            pop,
  output tlpi_pkg::item_t      head,
  output logic                 full,
  output logic                 empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  tlpi_pkg::item_t mem [DEPTH];
  logic [PW-1:0]   wr_r, rd_r;
  logic [NW-1:0]   cnt_r;

  assign full  = (cnt_r == NW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rd_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> design/tlpi_back.sv
// Back end: multiply by focal length, pipelined divide on three lanes,
// lens offset, mirror and saturation, output register. Uses tlpi_pkg.
`default_nettype none
module tlpi_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire tlpi_pkg::cfg_t  cfg,
  input  wire tlpi_pkg::item_t head,
  input  wire logic            q_empty,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output tlpi_pkg::out_t       out_data
);
  localparam int CW = tlpi_pkg::CW;
  localparam int SW = tlpi_pkg::SW;
  localparam int NS = CW + 2;

  logic               adv;
  logic [NS:0]        vld_r;
  tlpi_pkg::stage_t   stg_r [NS+1];
  tlpi_pkg::stage_t   init;
  logic [2:0][CW:0]   mag;
  logic [2:0][2*CW-1:0] prod;
  logic               out_valid_r;
  tlpi_pkg::out_t     out_r, out_nxt;

  assign adv       = !out_valid_r || !out_stall;
  assign q_pop     = adv && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Multiply magnitudes by focal length
  always_comb begin
    init.close = head.close;
    init.den   = head.den;
    for (int k = 0; k < 3; k++) begin
      mag[k]  = head.diff[k][CW] ? (CW+1)'(-head.diff[k]) : head.diff[k];
      prod[k] = (2*CW)'(mag[k]) * (2*CW)'(cfg.focal);
      init.lane[k].rem = (CW+2)'(prod[k][2*CW-1:CW+1]);
      init.lane[k].low = prod[k][CW:0];
      init.lane[k].quo = '0;
      init.lane[k].ovf = 1'b0;
      init.lane[k].neg = head.diff[k][CW];
    end
  end

  // Advance the divider pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-1:0], q_pop};
    end
    if (adv) begin
      stg_r[0] <= init;
      stg_r[1] <= tlpi_pkg::div_check(stg_r[0]);
      for (int s = 1; s < NS; s++) begin
        stg_r[s+1] <= tlpi_pkg::div_step(stg_r[s]);
      end
    end
  end

  // Apply lens offset, mirror and saturation
  always_comb begin
    logic [2:0][CW:0]        res;
    logic signed [SW-1:0]    lens [3];
    logic [CW+1:0]           qf;
    logic signed [SW-1:0]    r, mz;
    logic [CW:0]             mres;
    logic                    ovf;
    lens[0] = SW'(cfg.lens_x);
    lens[1] = SW'(cfg.lens_y);
    lens[2] = SW'(cfg.lens_z);
    ovf = 1'b0;
    for (int k = 0; k < 3; k++) begin
      qf = stg_r[NS].lane[k].ovf ? ((CW+2)'(1) << (CW+1)) : {1'b0, stg_r[NS].lane[k].quo};
      r  = stg_r[NS].lane[k].neg ? lens[k] + $signed(SW'(qf)) : lens[k] - $signed(SW'(qf));
      res[k] = stg_r[NS].close ? '0 : tlpi_pkg::sat_c(r);
      ovf = ovf | res[k][CW];
    end
    mz = ((lens[2] + (SW'($signed({1'b0, cfg.focal})) <<< 1)) <<< 1)
         - SW'($signed(res[2][CW-1:0]));
    mres = cfg.mode ? tlpi_pkg::sat_c(mz) : '0;
    out_nxt.image_x    = res[0][CW-1:0];
    out_nxt.image_y    = res[1][CW-1:0];
    out_nxt.image_z    = res[2][CW-1:0];
    out_nxt.mirrored_z = mres[CW-1:0];
    out_nxt.too_close  = stg_r[NS].close;
    out_nxt.overflow   = ovf | mres[CW];
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[NS];
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/tlpi_checker.sv
// Port-level checks for thin_lens_point_imager_core, attached by bind.
// Depends on tlpi_pkg for the result type.
`default_nettype none
module tlpi_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_stall,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire tlpi_pkg::out_t out_data,
  input wire logic           cfg_ready
);

  // Drop pending results and stalls on reset
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");
  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("in_stall after reset");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A too-close point images to the origin
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.too_close |->
      out_data.image_x == '0 && out_data.image_y == '0 && out_data.image_z == '0)
    else $error("too-close image not at origin");

  // Configuration is always taken
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("cfg_ready low");

endmodule

bind thin_lens_point_imager_core tlpi_checker u_tlpi_checker (.*);
`default_nettype wire
